// File: hw/rtl/vln_pkg.sv
package vln_pkg;

    localparam int MAX_DIM_DEF      = 64;
    localparam int ELEMENT_BITS_DEF = 24;
    localparam int SUM_BITS         = 54;
    localparam int NORM_BITS        = 27;
    localparam int QUO_BITS         = 62;
    localparam int CFG_BITS         = 7;

    localparam logic CFG_IDX_MODE   = 1'b0;
    localparam logic CFG_IDX_LENGTH = 1'b1;

    localparam logic [1:0] MODE_COSINE = 2'd1;

    typedef struct packed {
        logic [ELEMENT_BITS_DEF-1:0] element;
        logic                        end_of_batch;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last_of_vector;
        logic        batch_done;
        logic        zero_norm;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic sqrt_start;
        logic rd_start;
        logic div_start;
        logic emit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic norm_zero;
        logic last_elem;
    } status_t;

endpackage

// File: hw/rtl/vln_ctrl.sv
module vln_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vec_end,
    input  vln_pkg::status_t status,
    output vln_pkg::cmd_t    cmd,
    output logic             busy
);

    vln_pkg::state_t state_reg;
    vln_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vln_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            vln_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (vec_end)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = vln_pkg::ST_SQRT;
                end
            end
            vln_pkg::ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = vln_pkg::ST_READ;
                end
            end
            vln_pkg::ST_READ:
            begin
                // buffer read data lands this cycle
                if (status.norm_zero)
                begin
                    state_next = vln_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = vln_pkg::ST_DIV;
                end
            end
            vln_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = vln_pkg::ST_EMIT;
                end
            end
            vln_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.last_elem)
                begin
                    cmd.clear  = 1'b1;
                    state_next = vln_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = vln_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = vln_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/vln_datapath.sv
module vln_datapath #(
    parameter int MAX_DIM = vln_pkg::MAX_DIM_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [vln_pkg::ELEMENT_BITS_DEF-1:0]  element,
    input  logic                                  end_of_batch,
    input  logic                                  cfg_write,
    input  logic [1:0]                            mode,
    input  logic [6:0]                            length,
    input  vln_pkg::cmd_t                         cmd,
    output vln_pkg::status_t                      status,
    output logic                                  vec_end,
    output logic                                  res_valid,
    output vln_pkg::out_item_t                    res
);

    localparam int ELEMENT_BITS = vln_pkg::ELEMENT_BITS_DEF;
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int SB = vln_pkg::SUM_BITS;
    localparam int NB = vln_pkg::NORM_BITS;
    localparam int QB = vln_pkg::QUO_BITS;
    localparam int DB = ELEMENT_BITS + 30;

    logic signed [ELEMENT_BITS-1:0] buf_mem [MAX_DIM];
    logic [CW-1:0]      count_reg;
    logic [SB-1:0]      sum_reg;
    logic               pend_reg;
    logic [CW-1:0]      eff_len;
    logic               last_in;
    logic [ELEMENT_BITS-1:0] mag_in;
    logic [2*ELEMENT_BITS-1:0] sq_in;
    logic [SB:0]        sum_add;
    logic [SB-1:0]      sum_sat;
    logic [AW-1:0]      wr_idx;

    always_comb
    begin
        if (length == 7'd0)
        begin
            eff_len = CW'(1);
        end
        else if ({25'd0, length} > MAX_DIM)
        begin
            eff_len = CW'(MAX_DIM);
        end
        else
        begin
            eff_len = CW'(length);
        end
    end

    assign last_in = ((32'(count_reg) + 32'd1) >= 32'(eff_len)) || end_of_batch;
    assign mag_in  = element[ELEMENT_BITS-1] ? (~element + 1'b1) : element;
    assign sq_in   = {{ELEMENT_BITS{1'b0}}, mag_in} * {{ELEMENT_BITS{1'b0}}, mag_in};
    assign sum_add = {1'b0, sum_reg} + (SB+1)'(sq_in);
    assign sum_sat = (sum_add[SB] || (2*ELEMENT_BITS > SB && |(sq_in >> SB)))
                     ? {SB{1'b1}} : sum_add[SB-1:0];
    assign wr_idx  = (32'(count_reg) >= MAX_DIM) ? AW'(MAX_DIM - 1) : AW'(count_reg);

    logic cos_mode;
    assign cos_mode = (mode == vln_pkg::MODE_COSINE);
    assign vec_end  = accept && cos_mode && last_in;

    // pass-through result
    logic pt_valid_reg;
    vln_pkg::out_item_t pt_reg;

    always_ff @(posedge clk)
    begin
        if (accept && cos_mode)
        begin
            buf_mem[wr_idx] <= element;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            pend_reg     <= 1'b0;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            pt_valid_reg <= accept && !cos_mode;
            if (cfg_write || cmd.clear)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                pend_reg  <= 1'b0;
            end
            else if (accept)
            begin
                if (cos_mode)
                begin
                    count_reg <= CW'(wr_idx) + CW'(1);
                    sum_reg   <= sum_sat;
                    if (end_of_batch)
                    begin
                        pend_reg <= 1'b1;
                    end
                end
                else
                begin
                    count_reg <= last_in ? '0 : count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cos_mode)
        begin
            pt_reg.value          <= 32'(signed'(element));
            pt_reg.last_of_vector <= last_in;
            pt_reg.batch_done     <= end_of_batch;
            pt_reg.zero_norm      <= 1'b0;
        end
    end

    // bit-pair square root, one result bit a cycle
    logic [SB+1:0]  rem_reg;
    logic [NB-1:0]  root_reg;
    logic [SB-1:0]  rad_reg;
    logic [4:0]     sq_cnt_reg;
    logic           sq_busy_reg;
    logic [SB+1:0]  rem_shift;
    logic [SB+1:0]  trial;

    assign rem_shift = {rem_reg[SB-1:0], rad_reg[SB-1 -: 2]};
    assign trial     = (SB+2)'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
            sq_cnt_reg  <= 5'(NB - 1);
        end
        else if (sq_busy_reg)
        begin
            sq_cnt_reg <= sq_cnt_reg - 5'd1;
            if (sq_cnt_reg == 5'd0)
            begin
                sq_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            // take the sum including the square of the closing element
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= sum_sat;
        end
        else if (sq_busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[NB-2:0], 1'b0};
            end
        end
    end

    assign status.sqrt_done = sq_busy_reg && (sq_cnt_reg == 5'd0);
    assign status.norm_zero = (root_reg == '0);

    // element read-out
    logic [CW-1:0] rd_cnt_reg;
    logic signed [ELEMENT_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            rd_cnt_reg <= '0;
        end
        else if (cmd.rd_start)
        begin
            rd_cnt_reg <= rd_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
        begin
            rd_data_reg <= buf_mem[rd_cnt_reg[AW-1:0]];
        end
    end

    assign status.last_elem = (rd_cnt_reg == count_reg);

    // restoring divider, one quotient bit a cycle
    logic [QB-1:0] quo_reg;
    logic [NB:0]   drem_reg;
    logic [DB-1:0] dvd_reg;
    logic [5:0]    dv_cnt_reg;
    logic          dv_busy_reg;
    logic          neg_reg;
    logic [NB:0]   drem_shift;

    assign drem_shift = {drem_reg[NB-1:0], dvd_reg[DB-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= 6'(DB - 1);
        end
        else if (dv_busy_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg - 6'd1;
            if (dv_cnt_reg == 6'd0)
            begin
                dv_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg  <= rd_data_reg[ELEMENT_BITS-1];
            dvd_reg  <= {(rd_data_reg[ELEMENT_BITS-1] ? (~rd_data_reg + 1'b1) : rd_data_reg),
                         30'd0};
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        else if (dv_busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (drem_shift >= {1'b0, root_reg})
            begin
                drem_reg <= drem_shift - {1'b0, root_reg};
                quo_reg  <= {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_shift;
                quo_reg  <= {quo_reg[QB-2:0], 1'b0};
            end
        end
    end

    assign status.div_done = dv_busy_reg && (dv_cnt_reg == 6'd0);

    logic [31:0] sat_val;

    always_comb
    begin
        if (neg_reg)
        begin
            sat_val = (quo_reg > QB'(33'h80000000)) ? 32'h80000000 : (~quo_reg[31:0] + 32'd1);
        end
        else
        begin
            sat_val = (quo_reg > QB'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo_reg[31:0];
        end
    end

    always_comb
    begin
        res_valid = pt_valid_reg || cmd.emit;
        res       = pt_reg;
        if (cmd.emit)
        begin
            res.value          = status.norm_zero ? 32'(rd_data_reg) : sat_val;
            res.last_of_vector = status.last_elem;
            res.batch_done     = status.last_elem && pend_reg;
            res.zero_norm      = status.norm_zero;
        end
    end

endmodule

// File: hw/rtl/vector_l2_normalizer_unit.sv
// channel   direction  handshake               payload
// command   in         start & !busy           in_item (element, end_of_batch)
// result    out        done strobe, one cycle  result (value, flags)
// config    in         cfg_we                  cfg_index, cfg_data
// Pass-through modes: result in the cycle after start, a new element every cycle.
// Cosine mode: elements are accepted one per cycle; the last one starts the square
// root, then each element is read back, divided by the root unless it is zero, and emitted.
// busy stays high over the root and the whole burst; rst_n clears control state.
// Results cannot be stalled.
module vector_l2_normalizer_unit #(
    parameter int MAX_DIM = vln_pkg::MAX_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  vln_pkg::in_item_t                  in_item,
    output logic                               done,
    output vln_pkg::out_item_t                 result,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [vln_pkg::CFG_BITS-1:0]       cfg_data
);

    logic [1:0]        mode_reg;
    logic [6:0]        length_reg;
    logic              accept;
    logic              vec_end;
    vln_pkg::cmd_t     cmd;
    vln_pkg::status_t  status;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            length_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vln_pkg::CFG_IDX_MODE:   mode_reg   <= cfg_data[1:0];
                vln_pkg::CFG_IDX_LENGTH: length_reg <= cfg_data[6:0];
                default:                 mode_reg   <= mode_reg;
            endcase
        end
    end

    vln_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .vec_end (vec_end),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    vln_datapath #(
        .MAX_DIM      (MAX_DIM)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .element      (in_item.element),
        .end_of_batch (in_item.end_of_batch),
        .cfg_write    (cfg_we),
        .mode         (mode_reg),
        .length       (length_reg),
        .cmd          (cmd),
        .status       (status),
        .vec_end      (vec_end),
        .res_valid    (done),
        .res          (result)
    );

`ifndef ASSERT_OFF
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (cmd.emit && result.last_of_vector))
        else $error("clear without last result");
    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        vec_end |=> busy)
        else $error("vector end did not raise busy");
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_norm) |-> cmd.emit)
        else $error("zero_norm outside cosine burst");
`endif

endmodule
